FILE: hw/rtl/ypcb_pkg.sv
// ----------------------------------------------------------------------------
// ypcb_pkg
// Types and constants shared by the yaw/pitch camera basis block.
// ----------------------------------------------------------------------------
package ypcb_pkg;

    localparam int AngW = 25;
    localparam int PitW = 24;
    localparam int VecW = 16;
    localparam int CorW = 34;
    localparam int ZW   = 33;
    localparam int AtanCount = 24;

    localparam logic signed [AngW-1:0] YawReset  = -25'sd5898240;
    localparam logic signed [AngW-1:0] YawHalf   = 25'sd11796480;
    localparam logic signed [27:0]     YawFull   = 28'sd23592960;
    localparam logic signed [PitW-1:0] PitchLim  = 24'sd5832704;
    localparam logic [15:0]            SensReset = 16'd6554;
    localparam logic signed [CorW-1:0] CorGain   = 34'sd652032874;
    localparam logic signed [ZW-1:0]   ZRight    = 33'sd1509949440;
    localparam logic signed [ZW-1:0]   ZStraight = 33'sd3019898880;

    typedef struct packed {
        logic signed [AngW-1:0] yaw;
        logic signed [PitW-1:0] pitch;
    } t_angles;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YAW,
        ST_PITCH,
        ST_OUT
    } t_state;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
        logic signed [ZW-1:0] a;
        a = '0;
        case (i)
            5'd0:  a = 33'sd754974720;
            5'd1:  a = 33'sd445687602;
            5'd2:  a = 33'sd235489088;
            5'd3:  a = 33'sd119537938;
            5'd4:  a = 33'sd60000934;
            5'd5:  a = 33'sd30029717;
            5'd6:  a = 33'sd15018523;
            5'd7:  a = 33'sd7509720;
            5'd8:  a = 33'sd3754917;
            5'd9:  a = 33'sd1877466;
            5'd10: a = 33'sd938734;
            5'd11: a = 33'sd469367;
            5'd12: a = 33'sd234683;
            5'd13: a = 33'sd117342;
            5'd14: a = 33'sd58671;
            5'd15: a = 33'sd29335;
            5'd16: a = 33'sd14668;
            5'd17: a = 33'sd7334;
            5'd18: a = 33'sd3667;
            5'd19: a = 33'sd1833;
            5'd20: a = 33'sd917;
            5'd21: a = 33'sd458;
            5'd22: a = 33'sd229;
            5'd23: a = 33'sd115;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [VecW-1:0] sat_unit(input logic signed [35:0] v);
        logic signed [VecW-1:0] r;
        if (v > 36'sd16384) begin
            r = 16'sd16384;
        end else if (v < -36'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = v[VecW-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/ypcb_front.sv
// ----------------------------------------------------------------------------
// ypcb_front
// Accepts delta requests, scales them, updates yaw and pitch, and pushes the
// new angle pair into a two-entry queue toward the basis engine.
// ----------------------------------------------------------------------------
module ypcb_front import ypcb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [15:0]             i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [15:0]      i_delta_x,
    input  logic signed [15:0]      i_delta_y,
    output logic                    o_q_valid,
    input  logic                    i_q_pop,
    output t_angles                 o_q_data
);

    localparam logic signed [29:0] YawFull1 = 30'(YawFull);
    localparam logic signed [29:0] YawFull2 = YawFull1 <<< 1;
    localparam logic signed [29:0] YawFull4 = YawFull1 <<< 2;
    localparam logic signed [29:0] YawFull8 = YawFull1 <<< 3;

    logic [15:0]            r_sens;
    logic signed [AngW-1:0] r_yaw;
    logic signed [PitW-1:0] r_pitch;
    t_angles                r_q [2];
    logic                   r_wp;
    logic                   r_rp;
    logic [1:0]             r_cnt;

    logic signed [32:0] n_mx;
    logic signed [32:0] n_my;
    logic signed [28:0] n_incx;
    logic signed [28:0] n_incy;
    logic signed [29:0] n_ys;
    logic signed [29:0] n_ps;
    logic signed [AngW-1:0] n_yaw;
    logic signed [PitW-1:0] n_pitch;
    logic               push;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_q[r_rp];

    always_comb begin
        n_mx   = 33'(i_delta_x) * $signed({1'b0, r_sens}) + 33'sd8;
        n_my   = 33'(i_delta_y) * $signed({1'b0, r_sens}) + 33'sd8;
        n_incx = n_mx[32:4];
        n_incy = n_my[32:4];
        // bias by eight turns, then strip turns in binary steps
        n_ys   = 30'(r_yaw) + 30'(n_incx) + 30'(YawHalf) + YawFull8;
        if (n_ys >= YawFull8) begin
            n_ys = n_ys - YawFull8;
        end
        if (n_ys >= YawFull4) begin
            n_ys = n_ys - YawFull4;
        end
        if (n_ys >= YawFull2) begin
            n_ys = n_ys - YawFull2;
        end
        if (n_ys >= YawFull1) begin
            n_ys = n_ys - YawFull1;
        end
        n_yaw = AngW'(n_ys - 30'(YawHalf));
        n_ps  = 30'(r_pitch) + 30'(n_incy);
        if (n_ps > 30'(PitchLim)) begin
            n_pitch = PitchLim;
        end else if (n_ps < -30'(PitchLim)) begin
            n_pitch = -PitchLim;
        end else begin
            n_pitch = n_ps[PitW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens  <= SensReset;
            r_yaw   <= YawReset;
            r_pitch <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sens <= i_cfg_data;
            end
            if (push) begin
                r_yaw   <= n_yaw;
                r_pitch <= n_pitch;
                r_wp    <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{yaw: n_yaw, pitch: n_pitch};
        end
    end

    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    ap_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    ap_pitch_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pitch <= PitchLim && r_pitch >= -PitchLim) else $error("pitch out of range");

endmodule

FILE: hw/rtl/ypcb_back.sv
// ----------------------------------------------------------------------------
// ypcb_back
// Runs an iterative CORDIC for yaw then pitch, forms the basis products in
// the output state and holds the result in an output register.
// ----------------------------------------------------------------------------
module ypcb_back import ypcb_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    output logic                    o_q_pop,
    input  t_angles                 i_q_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [AngW-1:0]  o_yaw_deg,
    output logic signed [PitW-1:0]  o_pitch_deg,
    output logic signed [VecW-1:0]  o_back_x,
    output logic signed [VecW-1:0]  o_back_y,
    output logic signed [VecW-1:0]  o_back_z,
    output logic signed [VecW-1:0]  o_right_x,
    output logic signed [VecW-1:0]  o_right_z,
    output logic signed [VecW-1:0]  o_up_x,
    output logic signed [VecW-1:0]  o_up_y,
    output logic signed [VecW-1:0]  o_up_z
);

    localparam int NSteps = (CORDIC_STEPS < AtanCount) ? CORDIC_STEPS : AtanCount;

    t_state r_st, n_st;
    logic [4:0]             r_i;
    logic signed [CorW-1:0] r_x, r_y;
    logic signed [ZW-1:0]   r_z;
    logic                   r_flip;
    logic signed [CorW-1:0] r_sy, r_cy, r_sp, r_cp;
    logic [2:0]             r_k;
    t_angles                r_ang;
    logic                   r_ovalid;
    logic signed [VecW-1:0] r_o [8];

    logic signed [CorW-1:0] dx, dy;
    logic                   last;
    logic signed [ZW-1:0]   z0;
    logic                   f0;
    logic signed [ZW-1:0]   zin;
    logic signed [CorW-1:0] ma, mb;
    logic signed [67:0]     pr;
    logic signed [CorW-1:0] tv;
    logic signed [35:0]     tr;
    logic                   start_yaw;

    assign last      = (r_i == 5'(NSteps - 1));
    assign start_yaw = (r_st == ST_IDLE) && i_q_valid && !r_ovalid;
    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;

    always_comb begin
        zin = (r_st == ST_IDLE) ? ZW'(i_q_data.yaw) <<< 8 : ZW'(r_ang.pitch) <<< 8;
        z0 = zin;
        f0 = 1'b0;
        if (zin > ZRight) begin
            z0 = zin - ZStraight;
            f0 = 1'b1;
        end else if (zin < -ZRight) begin
            z0 = zin + ZStraight;
            f0 = 1'b1;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (start_yaw) n_st = ST_YAW;
            ST_YAW:   if (last) n_st = ST_PITCH;
            ST_PITCH: if (last) n_st = ST_OUT;
            ST_OUT:   if (r_k == 3'd7) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    assign o_q_pop = start_yaw;

    always_comb begin
        ma = r_cy; mb = r_cp; tv = r_sp;
        case (r_k)
            3'd0: begin ma = r_cy; mb = r_cp; tv = r_sp; end
            3'd1: begin ma = r_sy; mb = r_cp; tv = r_sy; end
            3'd2: begin ma = r_sp; mb = r_cy; tv = r_cy; end
            3'd3: begin ma = r_sp; mb = r_sy; tv = r_cp; end
            default: begin ma = r_cy; mb = r_cp; tv = r_sp; end
        endcase
        pr = 68'(ma) * 68'(mb) + (68'sd1 <<< 45);
        tr = 36'((36'(tv) + 36'sd32768) >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_k      <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_YAW || r_st == ST_PITCH) begin
                r_i <= last ? 5'd0 : r_i + 5'd1;
            end
            if (r_st == ST_OUT) begin
                r_k <= r_k + 3'd1;
            end else begin
                r_k <= '0;
            end
            if (r_st == ST_OUT && r_k == 3'd7) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_yaw) begin
            r_ang  <= i_q_data;
            r_x    <= CorGain;
            r_y    <= '0;
            r_z    <= z0;
            r_flip <= f0;
        end else if (r_st == ST_YAW || r_st == ST_PITCH) begin
            if (last && r_st == ST_YAW) begin
                r_x    <= CorGain;
                r_y    <= '0;
                r_z    <= z0;
                r_flip <= f0;
            end else if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_q24(r_i);
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_q24(r_i);
            end
            if (last) begin
                if (r_st == ST_YAW) begin
                    r_sy <= r_flip ? -(r_y + ((r_z >= 0) ? dy : -dy))
                                   :  (r_y + ((r_z >= 0) ? dy : -dy));
                    r_cy <= r_flip ? -(r_x - ((r_z >= 0) ? dx : -dx))
                                   :  (r_x - ((r_z >= 0) ? dx : -dx));
                end else begin
                    r_sp <= r_flip ? -(r_y + ((r_z >= 0) ? dy : -dy))
                                   :  (r_y + ((r_z >= 0) ? dy : -dy));
                    r_cp <= r_flip ? -(r_x - ((r_z >= 0) ? dx : -dx))
                                   :  (r_x - ((r_z >= 0) ? dx : -dx));
                end
            end
        end
        if (r_st == ST_OUT) begin
            case (r_k)
                3'd0: begin
                    r_o[0] <= -sat_unit(36'(pr >>> 46));
                    r_o[1] <= -sat_unit(tr);
                end
                3'd1: begin
                    r_o[2] <= -sat_unit(36'(pr >>> 46));
                    r_o[3] <= -sat_unit(tr);
                end
                3'd2: begin
                    r_o[6] <= -sat_unit(36'(pr >>> 46));
                    r_o[4] <= sat_unit(tr);
                end
                3'd3: begin
                    r_o[7] <= -sat_unit(36'(pr >>> 46));
                    r_o[5] <= sat_unit(tr);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_yaw_deg   = r_ang.yaw;
    assign o_pitch_deg = r_ang.pitch;
    assign o_back_x    = r_o[0];
    assign o_back_y    = r_o[1];
    assign o_back_z    = r_o[2];
    assign o_right_x   = r_o[3];
    assign o_right_z   = r_o[4];
    assign o_up_x      = r_o[6];
    assign o_up_y      = r_o[5];
    assign o_up_z      = r_o[7];

    ap_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_st == ST_YAW) else $error("pop without start");
    ap_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT && r_k == 3'd7) |=> o_valid) else $error("result lost");
    ap_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_q_pop) else $error("start while result pending");

endmodule

FILE: hw/rtl/yaw_pitch_camera_basis.sv
// ----------------------------------------------------------------------------
// yaw_pitch_camera_basis
// Mouse-driven yaw/pitch camera: accumulates deltas and emits the basis.
//
//   channel   direction  signals
//   request   in         i_valid / o_ready, i_delta_x, i_delta_y
//   result    out        o_valid / i_ready, angles and eight basis terms
//   config    in         i_cfg_we, i_cfg_data (sensitivity)
//
// Each request runs the shared CORDIC for yaw then pitch, then the eight
// basis terms are formed from the sines and cosines.
// Reset is synchronous; yaw returns to -90 degrees, pitch to 0.
// A two-entry queue lets requests land while the engine is busy; a held
// result blocks the next start until taken.
// ----------------------------------------------------------------------------
module yaw_pitch_camera_basis import ypcb_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [15:0]             i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [15:0]      i_delta_x,
    input  logic signed [15:0]      i_delta_y,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [AngW-1:0]  o_yaw_deg,
    output logic signed [PitW-1:0]  o_pitch_deg,
    output logic signed [VecW-1:0]  o_back_x,
    output logic signed [VecW-1:0]  o_back_y,
    output logic signed [VecW-1:0]  o_back_z,
    output logic signed [VecW-1:0]  o_right_x,
    output logic signed [VecW-1:0]  o_right_z,
    output logic signed [VecW-1:0]  o_up_x,
    output logic signed [VecW-1:0]  o_up_y,
    output logic signed [VecW-1:0]  o_up_z
);

    logic    q_valid;
    logic    q_pop;
    t_angles q_data;

    ypcb_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_valid, .o_ready,
        .i_delta_x, .i_delta_y,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_data(q_data)
    );

    ypcb_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_data(q_data),
        .o_valid, .i_ready, .o_yaw_deg, .o_pitch_deg,
        .o_back_x, .o_back_y, .o_back_z, .o_right_x, .o_right_z,
        .o_up_x, .o_up_y, .o_up_z
    );

endmodule
